// ===== sv/ptlt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptlt_pkg: shared types and constants of the position-to-line tracker
// Table dimensions, field widths, item codes and the saturating add.
// ----------------------------------------------------------------------------
package ptlt_pkg;

  localparam int MAX_LINES = 1024;
  localparam int IDX_W     = $clog2(MAX_LINES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int LEN_BITS  = 16;
  localparam int POS_W     = 26;
  localparam int INS_W     = 16;
  localparam int CHAR_W    = 8;
  localparam int LINE_W    = 11;
  localparam int TOT_W     = CNT_W + LEN_BITS;
  localparam int SAT_W     = LEN_BITS + INS_W + 1;

  localparam int IN_DATA_W  = ((CHAR_W + POS_W + INS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((LINE_W + 7) / 8) * 8;

  localparam logic [CHAR_W-1:0]   NEWLINE_CHAR = 8'h0A;
  localparam logic [LEN_BITS-1:0] LEN_MAX      = {LEN_BITS{1'b1}};

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_FEED   = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_LOOKUP = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BEYOND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_OUT
  } state_t;

  // Adds b to a line length and clamps at the largest length.
  function automatic logic [LEN_BITS-1:0] sat_add(input logic [LEN_BITS-1:0] a,
                                                  input logic [INS_W-1:0]    b);
    logic [SAT_W-1:0] s;
    s = SAT_W'(a) + SAT_W'(b);
    if (s > SAT_W'(LEN_MAX)) begin
      return LEN_MAX;
    end
    return s[LEN_BITS-1:0];
  endfunction

endpackage

// ===== sv/ptlt_ram.sv =====
// ----------------------------------------------------------------------------
// ptlt_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ptlt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/position_to_line_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// position_to_line_tracker_unit: maps character positions to line numbers
// Records line lengths from a character stream, answers which line holds a
// position and grows a line by an inserted character count.
// ----------------------------------------------------------------------------
//  channel | ports              | fields (low bit up)
//  --------+--------------------+-------------------------------------------
//  input   | in_tdata, in_tuser | char_byte, position, insert_count; action
//  result  | out_tdata/out_tuser| line_number; status
//
//  Clear and feed items are applied when taken; the result is shown in the
//  cycle after. Lookup and insert walk the length RAM one entry per cycle
//  through its single read port, up to the line that holds the position.
//  One item is in flight at a time; in_tready is low until its result is
//  taken, and a stalled result holds. Reset empties the table at once.
// ----------------------------------------------------------------------------
module position_to_line_tracker_unit
  import ptlt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // char_byte, position, insert_count
  input  logic [1:0]            in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // line_number
  output logic [1:0]            out_tuser   // status
);

  localparam int POS_LO = CHAR_W;
  localparam int INS_LO = CHAR_W + POS_W;

  state_t              state_r, state_nxt;
  action_t             act_r, act_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [INS_W-1:0]    ins_r, ins_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [LEN_BITS-1:0] run_r, run_nxt;
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]    chk_idx_r, chk_idx_nxt;
  logic                vld_r, vld_nxt;
  logic [TOT_W-1:0]    total_r, total_nxt;
  logic [LINE_W-1:0]   line_r, line_nxt;
  status_t             status_r, status_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [LEN_BITS-1:0] ram_wdata;
  logic [LEN_BITS-1:0] ram_rdata;
  logic [TOT_W-1:0]    sum;

  logic [CHAR_W-1:0]   in_char;
  logic [POS_W-1:0]    in_pos;
  logic [INS_W-1:0]    in_ins;

  assign in_char = in_tdata[CHAR_W-1:0];
  assign in_pos  = in_tdata[POS_LO +: POS_W];
  assign in_ins  = in_tdata[INS_LO +: INS_W];
  assign sum     = total_r + TOT_W'(ram_rdata);

  ptlt_ram #(
    .WIDTH (LEN_BITS),
    .DEPTH (MAX_LINES)
  ) u_len_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      run_r   <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      run_r   <= run_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    pos_r     <= pos_nxt;
    ins_r     <= ins_nxt;
    rd_idx_r  <= rd_idx_nxt;
    chk_idx_r <= chk_idx_nxt;
    total_r   <= total_nxt;
    line_r    <= line_nxt;
    status_r  <= status_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    pos_nxt     = pos_r;
    ins_nxt     = ins_r;
    count_nxt   = count_r;
    run_nxt     = run_r;
    rd_idx_nxt  = rd_idx_r;
    chk_idx_nxt = chk_idx_r;
    vld_nxt     = vld_r;
    total_nxt   = total_r;
    line_nxt    = line_r;
    status_nxt  = status_r;
    ram_we      = 1'b0;
    ram_waddr   = count_r[IDX_W-1:0];
    ram_wdata   = sat_add(run_r, INS_W'(1));
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          act_nxt    = action_t'(in_tuser);
          pos_nxt    = in_pos;
          ins_nxt    = in_ins;
          line_nxt   = LINE_W'(1);
          status_nxt = STAT_OK;
          unique case (action_t'(in_tuser))
            ACT_CLEAR: begin
              count_nxt = '0;
              run_nxt   = '0;
              state_nxt = S_OUT;
            end
            ACT_FEED: begin
              if (in_char == NEWLINE_CHAR) begin
                if (count_r < CNT_W'(MAX_LINES)) begin
                  ram_we    = 1'b1;
                  count_nxt = count_r + CNT_W'(1);
                end else begin
                  status_nxt = STAT_FULL;
                end
                run_nxt = '0;
              end else begin
                run_nxt = sat_add(run_r, INS_W'(1));
              end
              state_nxt = S_OUT;
            end
            ACT_INSERT, ACT_LOOKUP: begin
              rd_idx_nxt = '0;
              vld_nxt    = 1'b0;
              total_nxt  = '0;
              state_nxt  = S_WALK;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_WALK: begin
        // Reads are issued one entry ahead; vld_r marks data of chk_idx_r.
        if (rd_idx_r < count_r) begin
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          chk_idx_nxt = rd_idx_r[IDX_W-1:0];
          vld_nxt     = 1'b1;
        end else begin
          vld_nxt = 1'b0;
        end
        if (vld_r) begin
          total_nxt = sum;
        end
        if (vld_r && (TOT_W'(pos_r) < sum)) begin
          line_nxt   = LINE_W'(chk_idx_r) + LINE_W'(1);
          status_nxt = STAT_OK;
          if (act_r == ACT_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = chk_idx_r;
            ram_wdata = sat_add(ram_rdata, ins_r);
          end
          vld_nxt   = 1'b0;
          state_nxt = S_OUT;
        end else if (!vld_r && (rd_idx_r >= count_r)) begin
          // Position lies in the unrecorded trailing line.
          line_nxt   = LINE_W'(count_r) + LINE_W'(1);
          status_nxt = (act_r == ACT_INSERT) ? STAT_BEYOND : STAT_OK;
          state_nxt  = S_OUT;
        end
      end

      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tdata = OUT_DATA_W'(line_r);
  assign out_tuser = status_r;

endmodule

// ===== sv/ptlt_checker.sv =====
// ----------------------------------------------------------------------------
// ptlt_checker: port-level checks of the position-to-line tracker
// Watches the handshakes and result codes; bound to the top level.
// ----------------------------------------------------------------------------
module ptlt_checker
  import ptlt_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser
);

  // Only one item is in flight: an accepted item blocks the input.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after an accepted item");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a result is pending");

  // Every result names a line from one up and a defined status.
  a_result_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[LINE_W-1:0] != '0) &&
                    ((out_tuser == STAT_OK) || (out_tuser == STAT_FULL) ||
                     (out_tuser == STAT_BEYOND))))
    else $error("result with line zero or unknown status");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) &&
                                     $stable(out_tuser)))
    else $error("stalled result changed or dropped");

endmodule

bind position_to_line_tracker_unit ptlt_checker u_ptlt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== bench/tb_position_to_line_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// tb_position_to_line_tracker_unit: self-checking bench for the line tracker
// Streams clear, feed, insert and lookup items into the unit and keeps its own
// line-length table to predict each result item. Every result item is compared
// field by field, in order. Backpressure and idle gaps vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_position_to_line_tracker_unit
  import ptlt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [LINE_W-1:0] line_no;
    status_t           status;
  } line_answer_t;

  class line_table_scoreboard;
    logic [LEN_BITS-1:0] len_tab [MAX_LINES];
    int unsigned         nlines;
    logic [LEN_BITS-1:0] run_len;
    line_answer_t        answers [$];
    int                  errors;

    function new();
      nlines  = 0;
      run_len = '0;
      errors  = 0;
    endfunction

    static function logic [LEN_BITS-1:0] clamp_add(logic [LEN_BITS-1:0] a,
                                                   logic [INS_W-1:0] b);
      longint unsigned s;
      s = longint'(a) + longint'(b);
      if (s > longint'(LEN_MAX)) begin
        return LEN_MAX;
      end
      return LEN_BITS'(s);
    endfunction

    // One-based line whose running total first exceeds pos.
    function int unsigned holding_line(logic [POS_W-1:0] pos);
      longint unsigned sum;
      sum = 0;
      for (int i = 0; i < nlines; i++) begin
        sum += len_tab[i];
        if (longint'(pos) < sum) begin
          return i + 1;
        end
      end
      return nlines + 1;
    endfunction

    function longint unsigned total_len();
      longint unsigned sum;
      sum = 0;
      for (int i = 0; i < nlines; i++) begin
        sum += len_tab[i];
      end
      return sum;
    endfunction

    function int pending();
      return answers.size();
    endfunction

    function void note_item(action_t act, logic [CHAR_W-1:0] ch, logic [POS_W-1:0] pos,
                            logic [INS_W-1:0] cnt);
      line_answer_t a;
      int unsigned  ln;
      a.line_no = LINE_W'(1);
      a.status  = STAT_OK;
      case (act)
        ACT_CLEAR: begin
          nlines  = 0;
          run_len = '0;
        end
        ACT_FEED: begin
          if (ch == NEWLINE_CHAR) begin
            if (nlines < MAX_LINES) begin
              len_tab[nlines] = clamp_add(run_len, INS_W'(1));
              nlines++;
            end else begin
              a.status = STAT_FULL;
            end
            run_len = '0;
          end else begin
            run_len = clamp_add(run_len, INS_W'(1));
          end
        end
        ACT_INSERT: begin
          ln        = holding_line(pos);
          a.line_no = LINE_W'(ln);
          if (ln > nlines) begin
            a.status = STAT_BEYOND;
          end else begin
            len_tab[ln-1] = clamp_add(len_tab[ln-1], cnt);
          end
        end
        default: begin
          a.line_no = LINE_W'(holding_line(pos));
        end
      endcase
      answers = {answers, a};
    endfunction

    function void check_result(logic [LINE_W-1:0] line_no, logic [1:0] status);
      line_answer_t want;
      if (answers.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result item: line %0d status %0d", line_no, status);
        end
        return;
      end
      want = answers.pop_front();
      if (want.line_no !== line_no || want.status !== status) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected line %0d status %0d, got line %0d status %0d",
                   want.line_no, want.status, line_no, status);
        end
      end
    endfunction
  endclass

  localparam int RANDOM_ITEMS = 556;
  localparam int PHASE_ITEMS  = 139;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  int idle_pct;
  int stall_pct;
  int hold_cycles;

  line_table_scoreboard sb = new();

  position_to_line_tracker_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  // Offers one item after a random gap and returns at the edge that takes it.
  task automatic send_item(input action_t act, input logic [CHAR_W-1:0] ch,
                           input logic [POS_W-1:0] pos, input logic [INS_W-1:0] cnt);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({cnt, pos, ch});
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    sb.note_item(act, ch, pos, cnt);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1) begin
        sb.check_result(out_tdata[LINE_W-1:0], out_tuser);
      end
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int                  pick;
    int                  sel;
    action_t             act;
    logic [CHAR_W-1:0]   ch;
    logic [POS_W-1:0]    pos;
    logic [INS_W-1:0]    cnt;
    longint unsigned     span;

    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ACT_CLEAR;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: lookups and inserts land on the trailing line.
    send_item(ACT_LOOKUP, 8'h00, '0, '0);
    send_item(ACT_INSERT, 8'hFF, '0, 16'd7);
    send_item(ACT_CLEAR, 8'hFF, '1, '1);
    // Lines of length 3, 1 and 3.
    send_item(ACT_FEED, 8'hFF, '1, '1);
    send_item(ACT_FEED, 8'h00, '0, '0);
    send_item(ACT_FEED, NEWLINE_CHAR, '0, '0);
    send_item(ACT_FEED, NEWLINE_CHAR, '1, '1);
    send_item(ACT_FEED, 8'h0B, '0, '0);
    send_item(ACT_FEED, 8'h09, '0, '0);
    send_item(ACT_FEED, NEWLINE_CHAR, '0, '0);
    send_item(ACT_LOOKUP, 8'h00, 26'd2, '0);
    send_item(ACT_LOOKUP, 8'h00, 26'd3, '1);
    send_item(ACT_LOOKUP, 8'h00, 26'd6, '0);
    send_item(ACT_LOOKUP, 8'h00, 26'd7, '0);
    send_item(ACT_LOOKUP, 8'h00, '1, '0);
    send_item(ACT_INSERT, 8'h00, 26'd3, '0);
    send_item(ACT_INSERT, 8'h00, 26'd3, 16'd5);
    send_item(ACT_INSERT, 8'h00, 26'd0, '1);
    send_item(ACT_INSERT, 8'h00, '1, '1);
    send_item(ACT_LOOKUP, 8'h00, 26'd65534, '0);
    send_item(ACT_LOOKUP, 8'h00, 26'd65535, '0);

    // A partial line is dropped by clear.
    send_item(ACT_FEED, 8'h41, '0, '0);
    send_item(ACT_CLEAR, 8'h00, '0, '0);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      case (k / PHASE_ITEMS)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 51;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 51;
        end
        default: begin
          idle_pct  = 23;
          stall_pct = 23;
        end
      endcase
      // Long hold-off on the result side while items keep coming.
      if (k == 60) begin
        hold_cycles = 400;
      end
      if (k == 360) begin
        drain_results();
      end
      pick = $urandom_range(99);
      ch   = CHAR_W'($urandom);
      pos  = POS_W'($urandom);
      cnt  = INS_W'($urandom);
      if (pick < 3) begin
        act = ACT_CLEAR;
      end else if (pick < 58) begin
        act = ACT_FEED;
        if ($urandom_range(4) == 0) begin
          ch = NEWLINE_CHAR;
        end
      end else begin
        act  = (pick < 73) ? ACT_INSERT : ACT_LOOKUP;
        span = sb.total_len();
        sel  = $urandom_range(9);
        if (sel < 5) begin
          pos = POS_W'($urandom_range(32'(span) + 1));
        end else if (sel == 5) begin
          pos = POS_W'(span);
        end else if (sel == 6) begin
          pos = (span == 0) ? '0 : POS_W'(span - 1);
        end
        sel = $urandom_range(9);
        if (sel < 4) begin
          cnt = INS_W'($urandom_range(15));
        end else if (sel == 4) begin
          cnt = '1;
        end
      end
      send_item(act, ch, pos, cnt);
    end

    stall_pct = 0;
    drain_results();
    repeat (1100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ptlt_pkg.sv
sv/ptlt_ram.sv
sv/position_to_line_tracker_unit.sv
sv/ptlt_checker.sv
bench/tb_position_to_line_tracker_unit.sv
